[src/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg - shared types and constants of the stepper position controller
// Item layouts, command and run mode codes, position helpers.
// ----------------------------------------------------------------------------
package spc_pkg;

    // width of the internal position, target and travel limit registers
    localparam int PW = 32;

    localparam int PULSE_WIDTH    = 100;
    localparam int MIN_PERIOD     = 2 * PULSE_WIDTH;
    localparam int PERIOD_RESET   = 500;
    localparam int MAX_POS_RESET  = 160000;

    typedef logic signed [PW-1:0] t_pos;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_RUN_CONT   = 3'd1,
        CMD_RUN_TRACK  = 3'd2,
        CMD_RUN_CAL    = 3'd3,
        CMD_STOP       = 3'd4,
        CMD_RESET_POS  = 3'd5,
        CMD_SET_TARGET = 3'd6
    } t_cmd_code;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_TRACK = 2'd1,
        RUN_CONT  = 2'd2,
        RUN_CAL   = 2'd3
    } t_run_mode;

    // configuration register indexes
    typedef enum logic {
        CFG_MAX_POS = 1'b0,
        CFG_MIN_POS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]         mode;
        logic               dir;
        logic [15:0]        speed;
        logic [31:0]        pulses;
        logic signed [31:0] target_value;
    } t_cmd_item;

    typedef struct packed {
        logic signed [31:0] position_now;
        logic signed [31:0] target_now;
        logic               step_output_on;
        logic               ticks_armed;
        logic               direction_out;
        logic [15:0]        period_out;
        logic               moving;
        logic [1:0]         mode_now;
    } t_res_item;

    typedef struct packed {
        t_pos        position;
        t_pos        target;
        t_run_mode   run_mode;
        logic        moving;
        logic        pulse_en;
        logic        armed;
        logic        direction;
        logic [15:0] period;
    } t_state;

    // 32-bit two's complement value to position width
    function automatic t_pos from32(logic [31:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[PW-1:0];
    endfunction

    // position width value, sign-extended, low 32 bits
    function automatic logic signed [31:0] to32(t_pos p);
        logic signed [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    function automatic t_pos step_pos(t_pos p, logic down);
        return down ? p - t_pos'(1) : p + t_pos'(1);
    endfunction

    function automatic t_pos clamp_pos(t_pos t, t_pos hi, t_pos lo);
        t_pos r;
        r = t;
        if (hi < r) r = hi;
        if (r < lo) r = lo;
        return r;
    endfunction

    function automatic logic [15:0] clamp_period(logic [15:0] s);
        return (s < 16'(MIN_PERIOD)) ? 16'(MIN_PERIOD) : s;
    endfunction

endpackage

[src/spc_cmd_if.sv]
// ----------------------------------------------------------------------------
// spc_cmd_if - command item channel
// Valid/ready channel carrying one command or tick item.
// ----------------------------------------------------------------------------
interface spc_cmd_if import spc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/spc_res_if.sv]
// ----------------------------------------------------------------------------
// spc_res_if - result item channel
// Valid/ready channel carrying one status item per command or tick item.
// ----------------------------------------------------------------------------
interface spc_res_if import spc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/spc_step.sv]
// ----------------------------------------------------------------------------
// spc_step - next-state logic of the controller
// Applies one command or tick item to the current motion state.
// ----------------------------------------------------------------------------
module spc_step import spc_pkg::*; (
    input  t_state    i_state,
    input  t_cmd_item i_item,
    input  t_pos      i_max_pos,
    input  t_pos      i_min_pos,
    output t_state    o_state
);

    always_comb begin
        t_state s;
        t_pos   t;
        t_pos   p;
        t_pos   pulses;
        s      = i_state;
        pulses = t_pos'(64'(i_item.pulses));
        t      = '0;
        p      = '0;
        unique case (i_item.mode)
            CMD_TICK: begin
                if (s.armed) begin
                    unique case (s.run_mode)
                        RUN_TRACK: begin
                            t        = clamp_pos(s.target, i_max_pos, i_min_pos);
                            s.target = t;
                            if (s.position == t) begin
                                s.pulse_en = 1'b0;
                                s.moving   = 1'b0;
                            end else begin
                                s.direction = t < s.position;
                                s.pulse_en  = 1'b1;
                                s.moving    = 1'b1;
                                s.position  = step_pos(s.position, t < s.position);
                            end
                        end
                        RUN_CONT: begin
                            p          = step_pos(s.position, s.direction);
                            s.position = p;
                            if (!(p < i_max_pos) || !(i_min_pos < p)) begin
                                s.pulse_en = 1'b0;
                                s.armed    = 1'b0;
                                s.moving   = 1'b0;
                            end
                        end
                        RUN_CAL: begin
                            if (s.position == s.target) begin
                                s.pulse_en = 1'b0;
                                s.armed    = 1'b0;
                                s.moving   = 1'b0;
                                s.position = '0;
                                s.target   = '0;
                            end else begin
                                s.pulse_en = 1'b1;
                                s.moving   = 1'b1;
                                s.position = step_pos(s.position, s.direction);
                            end
                        end
                        RUN_NONE: ;
                    endcase
                end
            end
            CMD_RUN_CONT: begin
                s.run_mode = RUN_CONT;
                // refused when already at the limit in the requested direction
                if (!((!i_item.dir && !(s.position < i_max_pos)) ||
                      (i_item.dir && !(i_min_pos < s.position)))) begin
                    s.direction = i_item.dir;
                    s.period    = clamp_period(i_item.speed);
                    s.pulse_en  = 1'b1;
                    s.armed     = 1'b1;
                    s.moving    = 1'b1;
                end
            end
            CMD_RUN_TRACK: begin
                t           = (s.run_mode != RUN_TRACK) ? s.position : s.target;
                s.run_mode  = RUN_TRACK;
                s.target    = clamp_pos(t, i_max_pos, i_min_pos);
                s.direction = 1'b0;
                s.period    = clamp_period(i_item.speed);
                s.pulse_en  = 1'b1;
                s.armed     = 1'b1;
                s.moving    = 1'b1;
            end
            CMD_RUN_CAL: begin
                t           = (s.run_mode != RUN_CAL) ? s.position : s.target;
                s.direction = i_item.dir;
                s.run_mode  = RUN_CAL;
                s.target    = i_item.dir ? t - pulses : t + pulses;
                s.period    = clamp_period(i_item.speed);
                s.pulse_en  = 1'b1;
                s.armed     = 1'b1;
                s.moving    = 1'b1;
            end
            CMD_STOP: begin
                s.pulse_en = 1'b0;
                s.armed    = 1'b0;
                s.moving   = 1'b0;
            end
            CMD_RESET_POS: begin
                s.position = '0;
                s.target   = '0;
            end
            CMD_SET_TARGET: begin
                s.target = from32(i_item.target_value);
            end
            default: ;
        endcase
        o_state = s;
    end

endmodule

[src/stepper_position_controller.sv]
// ----------------------------------------------------------------------------
// stepper_position_controller - step/direction motion controller
// Command and tick items in, one status item out per item.
// ----------------------------------------------------------------------------
// Every item on i_cmd (a step-completion tick or a command) yields exactly one
// status item on o_res, in order. An accepted item waits in the input register;
// the state update and the result register load happen together when it moves
// on, and that load raises o_res.valid. One item is taken every cycle while the
// result register is free or being drained; the rate is set by the single
// next-state pass in spc_step, whose longest path is the tracking tick (target
// clamp, position compare, step increment). The input stage keeps accepting
// while a result waits, as long as the result register is free or being
// drained. Travel limits are written through the plain config port (index 0
// max, index 1 min); the user must write them only while no item is in flight,
// as the block itself does not enforce this. Positions wrap modulo 2^32 and
// every position compare is signed.
// ----------------------------------------------------------------------------
module stepper_position_controller import spc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    spc_cmd_if.sink            i_cmd,
    spc_res_if.source          o_res
);

    // travel limits
    t_pos      r_max_pos;
    t_pos      r_min_pos;

    // motion state
    t_state    r_state;
    t_state    n_state;

    // input stage
    logic      r_in_valid;
    t_cmd_item r_in_item;

    // result stage
    logic      r_out_valid;
    t_res_item r_out_item;
    t_res_item n_out_item;

    // item in the input stage moves on when the result register can take it
    logic      advance;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_item;

    spc_step u_step (
        .i_state   (r_state),
        .i_item    (r_in_item),
        .i_max_pos (r_max_pos),
        .i_min_pos (r_min_pos),
        .o_state   (n_state)
    );

    always_comb begin
        n_out_item.position_now   = to32(n_state.position);
        n_out_item.target_now     = to32(n_state.target);
        n_out_item.step_output_on = n_state.pulse_en;
        n_out_item.ticks_armed    = n_state.armed;
        n_out_item.direction_out  = n_state.direction;
        n_out_item.period_out     = n_state.period;
        n_out_item.moving         = n_state.moving;
        n_out_item.mode_now       = n_state.run_mode;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pos <= from32(32'(MAX_POS_RESET));
            r_min_pos <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_POS: r_max_pos <= from32(i_cfg_data);
                CFG_MIN_POS: r_min_pos <= from32(i_cfg_data);
            endcase
        end
    end

    // state and handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.position  <= '0;
            r_state.target    <= '0;
            r_state.run_mode  <= RUN_NONE;
            r_state.moving    <= 1'b0;
            r_state.pulse_en  <= 1'b0;
            r_state.armed     <= 1'b0;
            r_state.direction <= 1'b0;
            r_state.period    <= 16'(PERIOD_RESET);
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_item <= i_cmd.data;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    // period is clamped whenever a run command sets it and resets above the floor
    a_period_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.period >= 16'(MIN_PERIOD))
        else $error("step period below floor");

    // pulses and the moving flag are always set and cleared together
    a_moving_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.moving == r_state.pulse_en)
        else $error("moving flag out of step with pulse enable");

    // pulses only run while ticks are armed
    a_pulse_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pulse_en |-> r_state.armed)
        else $error("pulses driven while disarmed");

    // arming always comes with a run mode
    a_armed_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |-> (r_state.run_mode != RUN_NONE))
        else $error("armed with no run mode");

    // an item that moves on always lands in the result register
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result lost after advance");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - stepper position controller check
// Drives command and tick items through the valid/ready command channel,
// predicts every status item with an independent motion model and compares
// the status channel field by field. A short table of hand-picked items comes
// first, then random traffic over several travel-limit windows, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import spc_pkg::*;

    // selector with no command behind it, ignored by the block
    localparam logic [2:0] SEL_UNUSED = 3'd7;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int PHASE_COUNT = 6;

    typedef struct {
        t_cmd_item item;
        bit        pinned;   // expected status typed in below
        t_res_item want;
    } t_step_row;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] cfg_data;

    spc_cmd_if cmd_bus ();
    spc_res_if res_bus ();

    stepper_position_controller u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Motion model: own copy of the controller state and travel limits
    // ------------------------------------------------------------------
    t_pos        pos;
    t_pos        tgt;
    t_run_mode   run_mode;
    logic        moving;
    logic        pulse_en;
    logic        armed;
    logic        dir_pin;
    logic [15:0] period;
    t_pos        lim_max;
    t_pos        lim_min;

    t_res_item   status_due [$];   // status items still owed by the block
    int          mismatch_count = 0;
    bit          calm = 1'b0;      // forces zero gaps and stalls
    int          stall_left = 0;
    t_res_item   oldest_due;

    function automatic void take_step();
        pos = dir_pin ? pos - 32'sd1 : pos + 32'sd1;
    endfunction

    function automatic void halt_motion();
        pulse_en = 1'b0;
        armed    = 1'b0;
        moving   = 1'b0;
    endfunction

    function automatic void start_motion(logic [15:0] speed);
        period   = (speed < 16'(MIN_PERIOD)) ? 16'(MIN_PERIOD) : speed;
        pulse_en = 1'b1;
        armed    = 1'b1;
        moving   = 1'b1;
    endfunction

    // upper bound first, so an inverted window ends on the lower limit
    function automatic void clamp_target();
        if (lim_max < tgt) tgt = lim_max;
        if (tgt < lim_min) tgt = lim_min;
    endfunction

    function automatic void tick_motion();
        if (!armed) return;
        case (run_mode)
            RUN_TRACK: begin
                clamp_target();
                if (pos == tgt) begin
                    // arrival keeps ticks armed
                    pulse_en = 1'b0;
                    moving   = 1'b0;
                end else begin
                    dir_pin  = (tgt < pos);
                    pulse_en = 1'b1;
                    moving   = 1'b1;
                    take_step();
                end
            end
            RUN_CONT: begin
                take_step();
                if (!(pos < lim_max) || !(lim_min < pos)) halt_motion();
            end
            RUN_CAL: begin
                if (pos == tgt) begin
                    halt_motion();
                    pos = '0;
                    tgt = '0;
                end else begin
                    // no steering: an overshoot wraps around
                    pulse_en = 1'b1;
                    moving   = 1'b1;
                    take_step();
                end
            end
            default: ;
        endcase
    endfunction

    // apply one accepted item, return the status it must produce
    function automatic t_res_item advance_motion(t_cmd_item it);
        t_res_item r;
        case (it.mode)
            CMD_TICK: tick_motion();
            CMD_RUN_CONT: begin
                run_mode = RUN_CONT;
                // refused at a limit: only the mode changes
                if (!(!it.dir && !(pos < lim_max)) && !(it.dir && !(lim_min < pos))) begin
                    dir_pin = it.dir;
                    start_motion(it.speed);
                end
            end
            CMD_RUN_TRACK: begin
                if (run_mode != RUN_TRACK) tgt = pos;
                run_mode = RUN_TRACK;
                clamp_target();
                dir_pin = 1'b0;
                start_motion(it.speed);
            end
            CMD_RUN_CAL: begin
                dir_pin = it.dir;
                if (run_mode != RUN_CAL) tgt = pos;
                run_mode = RUN_CAL;
                tgt = it.dir ? tgt - it.pulses : tgt + it.pulses;
                start_motion(it.speed);
            end
            CMD_STOP:       halt_motion();
            CMD_RESET_POS: begin
                pos = '0;
                tgt = '0;
            end
            CMD_SET_TARGET: tgt = it.target_value;
            default: ;
        endcase
        r.position_now   = pos;
        r.target_now     = tgt;
        r.step_output_on = pulse_en;
        r.ticks_armed    = armed;
        r.direction_out  = dir_pin;
        r.period_out     = period;
        r.moving         = moving;
        r.mode_now       = run_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_cmd_item make_cmd(logic [2:0] m, logic d, logic [15:0] spd,
                                           logic [31:0] pls, logic [31:0] tv);
        t_cmd_item it;
        it.mode         = m;
        it.dir          = d;
        it.speed        = spd;
        it.pulses       = pls;
        it.target_value = tv;
        return it;
    endfunction

    function automatic t_step_row loose(t_cmd_item it);
        t_step_row r;
        r.item   = it;
        r.pinned = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_step_row pinned(t_cmd_item it, t_res_item w);
        t_step_row r;
        r.item   = it;
        r.pinned = 1'b1;
        r.want   = w;
        return r;
    endfunction

    function automatic int idle_cycles();
        return calm ? 0 : int'($urandom_range(0, 8));
    endfunction

    // mostly ticks so moves run their course; targets near the position
    function automatic t_cmd_item random_item();
        t_cmd_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      it.mode = CMD_TICK;
        else if (r < 63) it.mode = CMD_RUN_CONT;
        else if (r < 70) it.mode = CMD_RUN_TRACK;
        else if (r < 76) it.mode = CMD_RUN_CAL;
        else if (r < 80) it.mode = CMD_STOP;
        else if (r < 83) it.mode = CMD_RESET_POS;
        else if (r < 98) it.mode = CMD_SET_TARGET;
        else             it.mode = SEL_UNUSED;
        it.dir = 1'($urandom);
        it.speed = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        it.pulses = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
        it.target_value = ($urandom_range(0, 3) == 0) ? $urandom
                                                       : pos + $urandom_range(0, 60) - 30;
        return it;
    endfunction

    task automatic send_item(input t_cmd_item it, input bit fixed, input t_res_item want);
        int gap;
        t_res_item pred;
        gap = idle_cycles();
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.data  <= it;
        do @(posedge clk); while (!cmd_bus.ready);
        pred = advance_motion(it);
        status_due.push_back(fixed ? want : pred);
    endtask

    // hold the sender until every owed status item is back, then let the pipe settle
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both limits in back-to-back writes, enable held across them
    task automatic set_limits(input logic [31:0] hi, input logic [31:0] lo);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAX_POS;
        cfg_data <= hi;
        @(posedge clk);
        cfg_idx  <= CFG_MIN_POS;
        cfg_data <= lo;
        @(posedge clk);
        cfg_we   <= 1'b0;
        lim_max = hi;
        lim_min = lo;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    task automatic compare_status(input t_res_item got, input t_res_item want);
        if (got.position_now !== want.position_now)
            report_mismatch("position_now", got.position_now, want.position_now);
        if (got.target_now !== want.target_now)
            report_mismatch("target_now", got.target_now, want.target_now);
        if (got.step_output_on !== want.step_output_on)
            report_mismatch("step_output_on", got.step_output_on, want.step_output_on);
        if (got.ticks_armed !== want.ticks_armed)
            report_mismatch("ticks_armed", got.ticks_armed, want.ticks_armed);
        if (got.direction_out !== want.direction_out)
            report_mismatch("direction_out", got.direction_out, want.direction_out);
        if (got.period_out !== want.period_out)
            report_mismatch("period_out", got.period_out, want.period_out);
        if (got.moving !== want.moving)
            report_mismatch("moving", got.moving, want.moving);
        if (got.mode_now !== want.mode_now)
            report_mismatch("mode_now", got.mode_now, want.mode_now);
    endtask

    // status sink: random stall after each item, compare in order
    always @(posedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
        end else if (res_bus.valid && res_bus.ready) begin
            if (status_due.size() == 0) begin
                report_mismatch("status item with nothing pending", 0, 0);
            end else begin
                oldest_due = status_due.pop_front();
                compare_status(res_bus.data, oldest_due);
            end
            stall_left = idle_cycles();
            if (stall_left > 0) res_bus.ready <= 1'b0;
        end else if (!res_bus.ready) begin
            if (stall_left > 0) stall_left--;
            if (stall_left == 0) res_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_step_row   rows [$];
        t_cmd_item   it;
        int          ph;
        int          counted;
        bit          paused;
        logic [31:0] lo;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= CFG_MAX_POS;
        cfg_data      <= '0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.data  <= '0;

        // state after reset
        pos      = '0;
        tgt      = '0;
        run_mode = RUN_NONE;
        moving   = 1'b0;
        pulse_en = 1'b0;
        armed    = 1'b0;
        dir_pin  = 1'b0;
        period   = 16'(PERIOD_RESET);
        lim_max  = MAX_POS_RESET;
        lim_min  = '0;

        // directed items, default limits 160000 / 0
        // disarmed tick right after reset: reset state
        rows.push_back(pinned(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 16'd500, 1'b0, RUN_NONE}));
        // unused selector: ignored
        rows.push_back(pinned(make_cmd(SEL_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF),
            t_res_item'{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 16'd500, 1'b0, RUN_NONE}));
        // continuous down at the lower limit: refused, mode still switches
        rows.push_back(pinned(make_cmd(CMD_RUN_CONT, 1'b1, 16'h1234, 32'd0, 32'd0),
            t_res_item'{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 16'd500, 1'b0, RUN_CONT}));
        // continuous up, zero speed clamps the period
        rows.push_back(pinned(make_cmd(CMD_RUN_CONT, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{32'sd0, 32'sd0, 1'b1, 1'b1, 1'b0, 16'd200, 1'b1, RUN_CONT}));
        rows.push_back(pinned(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{32'sd1, 32'sd0, 1'b1, 1'b1, 1'b0, 16'd200, 1'b1, RUN_CONT}));
        rows.push_back(loose(make_cmd(CMD_TICK, 1'b1, 16'd7, 32'd9, 32'd5)));
        rows.push_back(loose(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0)));
        // stop keeps the mode
        rows.push_back(pinned(make_cmd(CMD_STOP, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{32'sd3, 32'sd0, 1'b0, 1'b0, 1'b0, 16'd200, 1'b0, RUN_CONT}));
        rows.push_back(loose(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0)));
        // tracking run, widest period; direction pin forced low first
        rows.push_back(loose(make_cmd(CMD_RUN_TRACK, 1'b1, 16'hFFFF, 32'd0, 32'd0)));
        rows.push_back(loose(make_cmd(CMD_SET_TARGET, 1'b0, 16'd0, 32'd0, 32'd6)));
        repeat (4) rows.push_back(loose(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0)));
        // most negative target, clamped to the lower limit on the next tick
        rows.push_back(loose(make_cmd(CMD_SET_TARGET, 1'b0, 16'd0, 32'd0, 32'h8000_0000)));
        rows.push_back(loose(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0)));
        // zero-length calibration, arrival zeroes position and target
        rows.push_back(loose(make_cmd(CMD_RUN_CAL, 1'b0, 16'd199, 32'd0, 32'd0)));
        rows.push_back(pinned(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 16'd200, 1'b0, RUN_CAL}));
        // full-length calibration down: target wraps to +1, position overshoots
        rows.push_back(pinned(make_cmd(CMD_RUN_CAL, 1'b1, 16'd200, 32'hFFFF_FFFF, 32'd0),
            t_res_item'{32'sd0, 32'sd1, 1'b1, 1'b1, 1'b1, 16'd200, 1'b1, RUN_CAL}));
        rows.push_back(pinned(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{-32'sd1, 32'sd1, 1'b1, 1'b1, 1'b1, 16'd200, 1'b1, RUN_CAL}));
        rows.push_back(pinned(make_cmd(CMD_RESET_POS, 1'b0, 16'd0, 32'd0, 32'd0),
            t_res_item'{32'sd0, 32'sd0, 1'b1, 1'b1, 1'b1, 16'd200, 1'b1, RUN_CAL}));
        // set target is unclamped and leaves the mode alone
        rows.push_back(loose(make_cmd(CMD_SET_TARGET, 1'b1, 16'd0, 32'd0, 32'h7FFF_FFFF)));
        rows.push_back(loose(make_cmd(CMD_RUN_TRACK, 1'b1, 16'd201, 32'd0, 32'd0)));
        rows.push_back(loose(make_cmd(CMD_TICK, 1'b0, 16'd0, 32'd0, 32'd0)));
        rows.push_back(loose(make_cmd(CMD_STOP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) send_item(rows[i].item, rows[i].pinned, rows[i].want);

        // random traffic, one travel window per phase
        paused = 1'b0;
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: set_limits(32'd40, -32'sd40);
                    2: set_limits(32'h7FFF_FFFF, 32'h8000_0000);   // widest window
                    3: set_limits(-32'sd10, 32'sd10);              // inverted window
                    4: set_limits(32'sd3, 32'sd3);                 // single position
                    default: begin
                        lo = $urandom_range(0, 200) - 100;
                        set_limits(lo + $urandom_range(0, 60), lo);
                    end
                endcase
            end
            calm = 1'b1;
            send_item(make_cmd(CMD_RESET_POS, 1'b0, 16'd0, 32'd0, 32'd0), 1'b0, '0);
            counted = 0;
            while (counted < RANDOM_PER_PHASE) begin
                // back-to-back burst at the head of each phase
                if (counted == 30) calm = 1'b0;
                if (ph == 1 && counted == 75 && !paused) begin
                    paused = 1'b1;
                    drain();
                end
                it = random_item();
                counted++;
                send_item(it, 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
